### hw/rtl/bsid_pkg.sv
// bsid_pkg: types, opcode constants and decode functions for the byte stream
// instruction decoder. No dependencies; used by bsid_decode, bsid_fifo and the core.
package bsid_pkg;

  localparam int FIFO_DEPTH = 3;

  // result forms
  localparam logic [2:0] FORM_RMR = 3'd0;
  localparam logic [2:0] FORM_IRM = 3'd1;
  localparam logic [2:0] FORM_IR  = 3'd2;
  localparam logic [2:0] FORM_IA  = 3'd3;
  localparam logic [2:0] FORM_JMP = 3'd4;
  localparam logic [2:0] FORM_BAD = 3'd5;

  // operations
  localparam logic [4:0] OP_MOV       = 5'd0;
  localparam logic [4:0] OP_ADD       = 5'd1;
  localparam logic [4:0] OP_SUB       = 5'd2;
  localparam logic [4:0] OP_CMP       = 5'd3;
  localparam logic [4:0] OP_JCC_BASE  = 5'd4;
  localparam logic [4:0] OP_LOOP_BASE = 5'd20;
  localparam logic [4:0] OP_BAD       = 5'd24;

  // arithmetic group extension codes (ModRM reg / opcode bits 5..3)
  localparam logic [2:0] EXT_ADD = 3'b000;
  localparam logic [2:0] EXT_SUB = 3'b101;

  localparam logic [2:0] RM_DIRECT = 3'b110;

  localparam logic [1:0] MOD_MEM   = 2'b00;
  localparam logic [1:0] MOD_DISP8 = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;

  // opcode masks and patterns
  localparam logic [7:0] MASK_FC = 8'hFC;
  localparam logic [7:0] MASK_FE = 8'hFE;
  localparam logic [7:0] MASK_F0 = 8'hF0;

  localparam logic [7:0] OPC_MOV_RM     = 8'h88;
  localparam logic [7:0] OPC_MOV_IMM_RM = 8'hC6;
  localparam logic [7:0] OPC_MOV_IMM_R  = 8'hB0;
  localparam logic [7:0] OPC_ADD_RM     = 8'h00;
  localparam logic [7:0] OPC_SUB_RM     = 8'h28;
  localparam logic [7:0] OPC_CMP_RM     = 8'h38;
  localparam logic [7:0] OPC_ADD_IA     = 8'h04;
  localparam logic [7:0] OPC_SUB_IA     = 8'h2C;
  localparam logic [7:0] OPC_CMP_IA     = 8'h3C;
  localparam logic [7:0] OPC_ARITH_IMM  = 8'h80;
  localparam logic [7:0] OPC_JCC        = 8'h70;
  localparam logic [7:0] OPC_LOOP       = 8'hE0;

  typedef struct packed {
    logic [2:0]        form;
    logic [4:0]        operation;
    logic              dir_bit;
    logic              wide;
    logic              sign_extend;
    logic [1:0]        mode;
    logic [2:0]        reg_field;
    logic [2:0]        rm_field;
    logic [15:0]       displacement;
    logic [15:0]       immediate;
    logic signed [7:0] jump_offset;
    logic [2:0]        length;
  } rec_t;

  typedef struct packed {
    logic push;
    logic halted;
  } dec_stat_t;

  function automatic logic [2:0] form_of(logic [7:0] b);
    logic [2:0] f;
    if ((b & MASK_FC) == OPC_MOV_RM) f = FORM_RMR;
    else if ((b & MASK_FE) == OPC_MOV_IMM_RM) f = FORM_IRM;
    else if ((b & MASK_F0) == OPC_MOV_IMM_R) f = FORM_IR;
    else if ((b & MASK_FC) == OPC_ADD_RM || (b & MASK_FC) == OPC_SUB_RM ||
             (b & MASK_FC) == OPC_CMP_RM) f = FORM_RMR;
    else if ((b & MASK_FE) == OPC_ADD_IA || (b & MASK_FE) == OPC_SUB_IA ||
             (b & MASK_FE) == OPC_CMP_IA) f = FORM_IA;
    else if ((b & MASK_FC) == OPC_ARITH_IMM) f = FORM_IRM;
    else if ((b & MASK_F0) == OPC_JCC) f = FORM_JMP;
    else if ((b & MASK_FC) == OPC_LOOP) f = FORM_JMP;
    else f = FORM_BAD;
    return f;
  endfunction

  function automatic logic is_arith(logic [7:0] b);
    return (b & MASK_FC) == OPC_ARITH_IMM;
  endfunction

  function automatic logic [4:0] op_from_bits(logic [2:0] sel);
    logic [4:0] op;
    if (sel == EXT_ADD) op = OP_ADD;
    else if (sel == EXT_SUB) op = OP_SUB;
    else op = OP_CMP;
    return op;
  endfunction

  function automatic logic wide_of(logic [7:0] b, logic [2:0] f);
    logic w;
    if (f == FORM_IR) w = b[3];
    else if (f == FORM_JMP || f == FORM_BAD) w = 1'b0;
    else w = b[0];
    return w;
  endfunction

  function automatic logic sbit_of(logic [7:0] b);
    return is_arith(b) & b[1];
  endfunction

  function automatic logic [1:0] imm_len(logic [7:0] b, logic [2:0] f);
    logic [1:0] n;
    if (f == FORM_RMR || f == FORM_BAD) n = 2'd0;
    else if (f == FORM_JMP) n = 2'd1;
    else if (wide_of(b, f) && !sbit_of(b)) n = 2'd2;
    else n = 2'd1;
    return n;
  endfunction

  function automatic logic [1:0] disp_len(logic [7:0] b, logic [7:0] m);
    logic [2:0] f;
    logic [1:0] n;
    f = form_of(b);
    if (f != FORM_RMR && f != FORM_IRM) n = 2'd0;
    else if (m[7:6] == MOD_MEM) n = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
    else if (m[7:6] == MOD_DISP8) n = 2'd1;
    else if (m[7:6] == MOD_DISP16) n = 2'd2;
    else n = 2'd0;
    return n;
  endfunction

  function automatic logic [15:0] sext8(logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  function automatic rec_t bad_record();
    rec_t r;
    r           = '0;
    r.form      = FORM_BAD;
    r.operation = OP_BAD;
    r.length    = 3'd1;
    return r;
  endfunction

  function automatic rec_t make_record(logic [7:0] b, logic [7:0] modrm,
                                       logic [15:0] disp, logic [15:0] imm,
                                       logic [2:0] needed);
    rec_t       r;
    logic [2:0] f;
    logic       hm;
    logic [7:0] m;
    logic [1:0] dl;
    logic [1:0] il;
    f  = form_of(b);
    hm = (f == FORM_RMR) || (f == FORM_IRM);
    m  = hm ? modrm : 8'h00;
    dl = disp_len(b, m);
    il = imm_len(b, f);
    r  = '0;
    r.form = f;
    case (f)
      FORM_RMR: r.operation = ((b & MASK_FC) == OPC_MOV_RM) ? OP_MOV : op_from_bits(b[5:3]);
      FORM_IRM: r.operation = is_arith(b) ? op_from_bits(m[5:3]) : OP_MOV;
      FORM_IR:  r.operation = OP_MOV;
      FORM_IA:  r.operation = op_from_bits(b[5:3]);
      default: begin
        if ((b & MASK_F0) == OPC_JCC) r.operation = OP_JCC_BASE + {1'b0, b[3:0]};
        else r.operation = OP_LOOP_BASE + {3'b000, b[1:0]};
      end
    endcase
    r.dir_bit     = (f == FORM_RMR) ? b[1] : 1'b0;
    r.wide        = wide_of(b, f);
    r.sign_extend = sbit_of(b);
    r.mode        = m[7:6];
    if (hm) r.reg_field = m[5:3];
    else if (f == FORM_IR) r.reg_field = b[2:0];
    else r.reg_field = 3'd0;
    r.rm_field = m[2:0];
    if (dl == 2'd1) r.displacement = sext8(disp[7:0]);
    else if (dl == 2'd2) r.displacement = disp;
    else r.displacement = 16'h0000;
    if (f == FORM_JMP) r.jump_offset = imm[7:0];
    else if (il == 2'd2) r.immediate = imm;
    else if (il == 2'd1) r.immediate = sbit_of(b) ? sext8(imm[7:0]) : {8'h00, imm[7:0]};
    r.length = needed;
    return r;
  endfunction

endpackage

### hw/rtl/bsid_byte_if.sv
// bsid_byte_if: valid/ready channel carrying one code byte per transaction.
// No dependencies.
interface bsid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

### hw/rtl/bsid_rec_if.sv
// bsid_rec_if: valid/ready channel carrying one decoded instruction record.
// No dependencies.
interface bsid_rec_if;
  logic              valid;
  logic              ready;
  logic [2:0]        form;
  logic [4:0]        operation;
  logic              dir_bit;
  logic              wide;
  logic              sign_extend;
  logic [1:0]        mode;
  logic [2:0]        reg_field;
  logic [2:0]        rm_field;
  logic [15:0]       displacement;
  logic [15:0]       immediate;
  logic signed [7:0] jump_offset;
  logic [2:0]        length;

  modport source (output valid, output form, output operation, output dir_bit,
                  output wide, output sign_extend, output mode, output reg_field,
                  output rm_field, output displacement, output immediate,
                  output jump_offset, output length, input ready);
  modport sink   (input valid, input form, input operation, input dir_bit,
                  input wide, input sign_extend, input mode, input reg_field,
                  input rm_field, input displacement, input immediate,
                  input jump_offset, input length, output ready);
endinterface

### hw/rtl/bsid_decode.sv
// bsid_decode: collection registers and per-byte decode; emits one record when
// an instruction completes. Depends on bsid_pkg.
module bsid_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  input  logic [7:0]            code_byte,
  output bsid_pkg::dec_stat_t   stat,
  output bsid_pkg::rec_t        rec
);

  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  modrm_byte, modrm_byte_next;
  logic [15:0] disp_collect, disp_collect_next;
  logic [15:0] imm_collect, imm_collect_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [2:0]  bytes_needed, bytes_needed_next;
  logic        halted, halted_next;

  logic [2:0]  f;
  logic        hm;
  logic [1:0]  dl;
  logic [2:0]  off;
  logic [2:0]  imm_off;
  logic        push;

  always_comb begin
    first_byte_next   = first_byte;
    modrm_byte_next   = modrm_byte;
    disp_collect_next = disp_collect;
    imm_collect_next  = imm_collect;
    bytes_seen_next   = bytes_seen;
    bytes_needed_next = bytes_needed;
    halted_next       = halted;
    push              = 1'b0;
    rec               = '0;
    f                 = bsid_pkg::form_of(first_byte);
    hm                = 1'b0;
    dl                = 2'd0;
    off               = 3'd0;
    imm_off           = 3'd0;
    if (valid && !halted) begin
      if (bytes_seen == 3'd0) begin
        f                 = bsid_pkg::form_of(code_byte);
        first_byte_next   = code_byte;
        modrm_byte_next   = 8'h00;
        disp_collect_next = 16'h0000;
        imm_collect_next  = 16'h0000;
        if (f == bsid_pkg::FORM_BAD) begin
          push              = 1'b1;
          rec               = bsid_pkg::bad_record();
          halted_next       = 1'b1;
          bytes_needed_next = 3'd0;
        end else begin
          if (f == bsid_pkg::FORM_RMR || f == bsid_pkg::FORM_IRM) begin
            bytes_needed_next = 3'd2;
          end else begin
            bytes_needed_next = 3'd1 + {1'b0, bsid_pkg::imm_len(code_byte, f)};
          end
          bytes_seen_next = 3'd1;
        end
      end else begin
        hm = (f == bsid_pkg::FORM_RMR) || (f == bsid_pkg::FORM_IRM);
        if (hm && bytes_seen == 3'd1) begin
          modrm_byte_next   = code_byte;
          bytes_needed_next = 3'd2 + {1'b0, bsid_pkg::disp_len(first_byte, code_byte)}
                              + {1'b0, bsid_pkg::imm_len(first_byte, f)};
        end else begin
          dl  = bsid_pkg::disp_len(first_byte, hm ? modrm_byte : 8'h00);
          off = bytes_seen - 3'd1 - {2'b00, hm};
          if (off < {1'b0, dl}) begin
            disp_collect_next = disp_collect |
                                (off[0] ? {code_byte, 8'h00} : {8'h00, code_byte});
          end else begin
            imm_off          = off - {1'b0, dl};
            imm_collect_next = imm_collect |
                               (imm_off[0] ? {code_byte, 8'h00} : {8'h00, code_byte});
          end
        end
        bytes_seen_next = bytes_seen + 3'd1;
        if (bytes_seen_next >= bytes_needed_next) begin
          push              = 1'b1;
          rec               = bsid_pkg::make_record(first_byte_next, modrm_byte_next,
                                                    disp_collect_next, imm_collect_next,
                                                    bytes_needed_next);
          bytes_seen_next   = 3'd0;
          bytes_needed_next = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte   <= 8'h00;
      modrm_byte   <= 8'h00;
      disp_collect <= 16'h0000;
      imm_collect  <= 16'h0000;
      bytes_seen   <= 3'd0;
      bytes_needed <= 3'd0;
      halted       <= 1'b0;
    end else begin
      first_byte   <= first_byte_next;
      modrm_byte   <= modrm_byte_next;
      disp_collect <= disp_collect_next;
      imm_collect  <= imm_collect_next;
      bytes_seen   <= bytes_seen_next;
      bytes_needed <= bytes_needed_next;
      halted       <= halted_next;
    end
  end

  assign stat.push   = push;
  assign stat.halted = halted;

endmodule

### hw/rtl/bsid_fifo.sv
// bsid_fifo: small record queue that forms the result register and absorbs
// output stalls. Depends on bsid_pkg.
module bsid_fifo #(
  parameter int DEPTH = bsid_pkg::FIFO_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  bsid_pkg::rec_t               push_data,
  input  logic                         pop,
  output bsid_pkg::rec_t               head_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  bsid_pkg::rec_t entries [DEPTH];
  logic [PW-1:0]  head, tail;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == LAST) ? '0 : head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign head_data = entries[head];

endmodule

### hw/rtl/byte_stream_instruction_decoder_core.sv
// byte_stream_instruction_decoder_core: top level of the 16-bit x86 subset
// decoder. Depends on bsid_pkg, bsid_byte_if, bsid_rec_if, bsid_decode, bsid_fifo.
//
// Usage:
//   byte_ch   code bytes of the instruction stream, one per transaction.
//   record_ch one decoded record per complete instruction (mov/add/sub/cmp
//             forms, conditional jumps, loop family, jcxz) with its length.
// A byte is registered on acceptance, decoded in the next cycle and the
// record is written to a FIFO_DEPTH-entry output queue; the record of an
// instruction is valid on record_ch as soon as the queue holds it. One byte
// is accepted every cycle while the queue has room: ready depends only on the
// queue fill and the staged byte, so a stalled receiver stops the byte channel
// once the queue holds FIFO_DEPTH-1 records with one byte in flight. Record
// order is kept, none is dropped.
// An unknown first byte yields an invalid record (form 5, length 1); after
// that, bytes are still accepted but ignored until reset.
// Reset (synchronous, active high) empties the queue and clears all
// collection state; the next byte is taken as a first byte.
module byte_stream_instruction_decoder_core #(
  parameter int FIFO_DEPTH = bsid_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  bsid_byte_if.sink   byte_ch,
  bsid_rec_if.source  record_ch
);

  localparam int CW = $clog2(FIFO_DEPTH+1);

  logic                 stage_valid;
  logic [7:0]           stage_byte;
  bsid_pkg::dec_stat_t  dec_stat;
  bsid_pkg::rec_t       dec_rec;
  bsid_pkg::rec_t       head_rec;
  logic [CW-1:0]        count;
  logic                 pop;

  assign byte_ch.ready = ({1'b0, count} + {{CW{1'b0}}, stage_valid})
                         <= (CW+1)'(FIFO_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= byte_ch.valid && byte_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      stage_byte <= byte_ch.code_byte;
    end
  end

  bsid_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .valid     (stage_valid),
    .code_byte (stage_byte),
    .stat      (dec_stat),
    .rec       (dec_rec)
  );

  bsid_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (dec_stat.push),
    .push_data (dec_rec),
    .pop       (pop),
    .head_data (head_rec),
    .count     (count)
  );

  assign pop                    = record_ch.valid && record_ch.ready;
  assign record_ch.valid        = (count != '0);
  assign record_ch.form         = head_rec.form;
  assign record_ch.operation    = head_rec.operation;
  assign record_ch.dir_bit      = head_rec.dir_bit;
  assign record_ch.wide         = head_rec.wide;
  assign record_ch.sign_extend  = head_rec.sign_extend;
  assign record_ch.mode         = head_rec.mode;
  assign record_ch.reg_field    = head_rec.reg_field;
  assign record_ch.rm_field     = head_rec.rm_field;
  assign record_ch.displacement = head_rec.displacement;
  assign record_ch.immediate    = head_rec.immediate;
  assign record_ch.jump_offset  = head_rec.jump_offset;
  assign record_ch.length       = head_rec.length;

  // queue never overflows: ready accounts for the staged byte
  assert property (@(posedge clk) disable iff (rst)
    !(dec_stat.push && !pop && count == CW'(FIFO_DEPTH)))
    else $error("record queue overflow");

  // once an invalid record is produced, the decoder stays halted
  assert property (@(posedge clk) disable iff (rst)
    dec_stat.push && dec_rec.form == bsid_pkg::FORM_BAD |=> dec_stat.halted)
    else $error("decoder not halted after invalid record");

  assert property (@(posedge clk) disable iff (rst)
    dec_stat.halted |-> !dec_stat.push)
    else $error("record produced while halted");

  // every record carries a length of one to six bytes
  assert property (@(posedge clk) disable iff (rst)
    dec_stat.push |-> (dec_rec.length != 3'd0 && dec_rec.length != 3'd7))
    else $error("record length out of range");

endmodule
